// ----- src/ssp_pkg.sv -----
package ssp_pkg;

  // action codes on the input tuser
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_CMD  = 2'd1;
  localparam logic [1:0] ACT_CAL  = 2'd2;

  // work classes handed from front to back
  typedef enum logic [1:0] {
    OP_NOP,
    OP_TICK,
    OP_CMD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] prod;   // steer_limit * clamped angle
  } job_t;

  localparam logic [7:0]         LIMIT_RESET = 8'd120;
  localparam logic [7:0]         POS_RESET   = 8'd90;
  localparam logic [12:0]        HIGH_RESET  = 13'd3000;
  localparam logic signed [10:0] ADC_MID     = 11'sd511;
  localparam logic [7:0]         ANGLE_MAX   = 8'd180;

  // reciprocals, exact over the value ranges in use
  localparam logic [20:0] CAL_RECIP  = 21'd2185;    // 2^16 / 30
  localparam logic [32:0] POS_RECIP  = 33'd93207;   // 2^24 / 180
  localparam logic [26:0] HIGH_RECIP = 27'd509740;  // just above 70 * 2^16 / 9
  localparam logic [12:0] HIGH_BASE  = 13'd800;

  // high time in ticks for a position: 2 * (pos * 700 / 90 + 800)
  function automatic logic [12:0] hi_ticks(input logic [7:0] pos);
    logic [26:0] p;
    logic [12:0] q;
    p = {19'b0, pos} * HIGH_RECIP;
    q = {2'b0, p[26:16]};
    return (q + HIGH_BASE) << 1;
  endfunction

endpackage

// ----- src/ssp_front.sv -----
module ssp_front
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] angle,
  input  logic [9:0] adc_sample,
  input  logic [7:0] steer_limit,
  output logic       push_valid,
  input  logic       push_ready,
  output job_t       push_job
);

  logic signed [5:0]  cal_offset;
  logic signed [5:0]  cal_offset_next;
  logic signed [10:0] diff;
  logic [9:0]         mag;
  logic [20:0]        quo_full;
  logic [5:0]         quo;
  logic signed [9:0]  sum;
  logic [7:0]         clamped;
  logic               fire;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign fire       = in_valid && push_ready;

  // calibration: (sample - 511) / 30 truncated toward zero
  always_comb begin
    diff     = $signed({1'b0, adc_sample}) - ADC_MID;
    mag      = diff[10] ? 10'(-diff) : diff[9:0];
    quo_full = {11'b0, mag} * CAL_RECIP;
    quo      = {1'b0, quo_full[20:16]};
    cal_offset_next = diff[10] ? $signed(-quo) : $signed(quo);
  end

  // command: add offset, clamp to 0..180, scale by limit
  always_comb begin
    sum = $signed({2'b0, angle}) + $signed({{4{cal_offset[5]}}, cal_offset});
    if (sum < 0) begin
      clamped = 8'd0;
    end else if (sum > $signed({2'b0, ANGLE_MAX})) begin
      clamped = ANGLE_MAX;
    end else begin
      clamped = sum[7:0];
    end
  end

  always_comb begin
    push_job.prod = {8'b0, steer_limit} * {8'b0, clamped};
    case (action)
      ACT_TICK: push_job.op = OP_TICK;
      ACT_CMD:  push_job.op = OP_CMD;
      default:  push_job.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset <= '0;
    end else if (fire && action == ACT_CAL) begin
      cal_offset <= cal_offset_next;
    end
  end

endmodule

// ----- src/ssp_queue.sv -----
module ssp_queue
  import ssp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/ssp_back.sv -----
module ssp_back
  import ssp_pkg::*;
#(
  parameter int PERIOD_TICKS = 40000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  job_t        pop_job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_data
);

  localparam logic [15:0] PERIOD_W = 16'(PERIOD_TICKS);

  logic [7:0]  steer_position, steer_position_next;
  logic [12:0] high_time, high_time_next;
  logic [15:0] phase_count, phase_count_next;
  logic        out_level, out_level_next;
  logic        running, running_next;
  logic [15:0] high_w;
  logic [15:0] low_time;
  logic [15:0] phase_limit;
  logic [15:0] count_inc;
  logic [32:0] scaled;
  logic        fire;

  assign pop_ready = !out_valid || out_ready;
  assign fire      = pop_valid && pop_ready;

  always_comb begin
    high_w    = {3'b0, high_time};
    low_time  = (high_w >= PERIOD_W) ? 16'd1 : PERIOD_W - high_w;
    phase_limit = out_level ? high_w : low_time;
    count_inc = phase_count + 16'd1;
    // limit * sum / 180
    scaled    = {17'b0, pop_job.prod} * POS_RECIP;

    steer_position_next = steer_position;
    high_time_next      = high_time;
    phase_count_next    = phase_count;
    out_level_next      = out_level;
    running_next        = running;

    case (pop_job.op)
      OP_TICK: begin
        if (running) begin
          phase_count_next = count_inc;
          if (count_inc >= phase_limit) begin
            phase_count_next = '0;
            out_level_next   = !out_level;
            // new high time latched only as a high phase opens
            if (!out_level) begin
              high_time_next = hi_ticks(steer_position);
            end
          end
        end
      end
      OP_CMD: begin
        steer_position_next = scaled[31:24];
        if (!running) begin
          // first command: next tick closes the low phase
          running_next     = 1'b1;
          out_level_next   = 1'b0;
          phase_count_next = low_time - 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_position <= POS_RESET;
      high_time      <= HIGH_RESET;
      phase_count    <= '0;
      out_level      <= 1'b0;
      running        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (fire) begin
        steer_position <= steer_position_next;
        high_time      <= high_time_next;
        phase_count    <= phase_count_next;
        out_level      <= out_level_next;
        running        <= running_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {2'b0, steer_position_next, high_time_next, out_level_next};
    end
  end

endmodule

// ----- src/servo_steering_pwm.sv -----
// servo steering pulse generator, 50 Hz frame counted in 0.5 us ticks
//
// input stream: one request per item; tuser selects the kind (tick,
// steering command, calibration sample), tdata carries angle and sample.
// every request yields exactly one result on the output stream: the pin
// level after the request, the high time in use and the scaled position.
// cfg channel writes steer_limit; it is always ready and is meant to be
// written only while no request is in flight.
//
// the front classifies a request, applies the calibration offset, clamps
// and multiplies by the limit in the accept cycle, then pushes into a small
// queue. the back pops one request per cycle while the output is not
// stalled, runs the pulse counter and fills the output register. a request
// passes the queue slot and then the output register on its way out.
//
// reset: limit 120, offset zero, position 90, high time 3000, pin low and
// the generator stopped until the first steering command arrives.
// a stalled receiver holds the output register; the back stops, the queue
// fills and then the input stops taking requests. nothing is dropped.
module servo_steering_pwm
  import ssp_pkg::*;
#(
  parameter int PERIOD_TICKS = 40000,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // angle[7:0], adc_sample[17:8], zero pad
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // pwm_level[0], pulse_ticks[13:1],
                                      // position[21:14], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // steer_limit
);

  logic [7:0] steer_limit;
  logic       push_valid;
  logic       push_ready;
  job_t       push_job;
  logic       pop_valid;
  logic       pop_ready;
  job_t       pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      steer_limit <= cfg_data;
    end
  end

  // classify, calibrate and pre-scale
  ssp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .action      (s_axis_tuser),
    .angle       (s_axis_tdata[7:0]),
    .adc_sample  (s_axis_tdata[17:8]),
    .steer_limit (steer_limit),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  // decouples front from a stalled back
  ssp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // pulse timing and result register
  ssp_back #(
    .PERIOD_TICKS (PERIOD_TICKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- dv/servo_steering_pwm_check.sv -----
module servo_steering_pwm_check
  import ssp_pkg::*;
#(
  parameter int PERIOD_TICKS = 40000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // angle[7:0], adc_sample[17:8], zero pad
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // pwm_level[0], pulse_ticks[13:1], position[21:14]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // steer_limit
  output int          outstanding,
  output int          mismatches,
  output int          reports_checked,
  output int          pulses_started
);

  typedef struct packed {
    logic [7:0]  position;     // tdata[21:14]
    logic [12:0] pulse_ticks;  // tdata[13:1]
    logic        pwm_level;    // tdata[0]
  } servo_report_t;

  logic [7:0]        limit_q;
  logic signed [5:0] offset_q;
  logic [7:0]        pos_q;
  logic [12:0]       high_q;
  logic [15:0]       count_q;
  logic              level_q;
  logic              running_q;
  servo_report_t     due_reports[$];
  int                n_bad = 0;
  int                n_checked = 0;
  int                n_pulses = 0;

  function automatic logic [15:0] low_ticks();
    if (int'(high_q) >= PERIOD_TICKS) begin
      return 16'd1;
    end
    return 16'(PERIOD_TICKS - int'(high_q));
  endfunction

  // advance the pulse generator by one request and report its state
  function automatic servo_report_t step_servo(input logic [1:0] act, input logic [7:0] ang,
                                              input logic [9:0] smp);
    int            sum;
    int            span;
    servo_report_t r;
    if (act == ACT_TICK) begin
      if (running_q) begin
        span = level_q ? int'(high_q) : int'(low_ticks());
        count_q = count_q + 16'd1;
        if (int'(count_q) >= span) begin
          count_q = '0;
          if (level_q) begin
            level_q = 1'b0;
          end else begin
            // new high time is taken only here
            level_q = 1'b1;
            high_q = 13'(2 * (int'(pos_q) * 700 / 90 + 800));
            n_pulses++;
          end
        end
      end
    end else if (act == ACT_CMD) begin
      sum = int'(ang) + int'(offset_q);
      if (sum > 180) begin
        sum = 180;
      end
      if (sum < 0) begin
        sum = 0;
      end
      pos_q = 8'(int'(limit_q) * sum / 180);
      if (!running_q) begin
        // first command: the next tick ends the low phase
        running_q = 1'b1;
        level_q = 1'b0;
        count_q = low_ticks() - 16'd1;
      end
    end else if (act == ACT_CAL) begin
      offset_q = 6'((int'(smp) - 511) / 30);
    end
    r.pwm_level = level_q;
    r.pulse_ticks = high_q;
    r.position = pos_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    servo_report_t got;
    servo_report_t want;
    if (rst) begin
      limit_q = LIMIT_RESET;
      offset_q = '0;
      pos_q = POS_RESET;
      high_q = HIGH_RESET;
      count_q = '0;
      level_q = 1'b0;
      running_q = 1'b0;
      due_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_q = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_reports.push_back(step_servo(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[17:8]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[21:0];
        if (due_reports.size() == 0) begin
          $error("result 0x%06h with no request waiting", m_axis_tdata);
          n_bad++;
        end else begin
          want = due_reports.pop_front();
          n_checked++;
          if (got.pwm_level !== want.pwm_level) begin
            $error("pwm_level: expected %0d, got %0d", want.pwm_level, got.pwm_level);
            n_bad++;
          end
          if (got.pulse_ticks !== want.pulse_ticks) begin
            $error("pulse_ticks: expected %0d, got %0d", want.pulse_ticks, got.pulse_ticks);
            n_bad++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            n_bad++;
          end
        end
      end
    end
    outstanding <= due_reports.size();
    mismatches <= n_bad;
    reports_checked <= n_checked;
    pulses_started <= n_pulses;
  end

endmodule

// ----- dv/servo_steering_pwm_test.sv -----
module servo_steering_pwm_test;
  import ssp_pkg::*;

  // a short frame, keeps the low phase short
  localparam int PERIOD         = 10000;
  localparam int CHANGES_PER_PH = 20;      // steering and calibration requests per phase
  localparam int SETTLE_CYCLES  = 8;       // pipeline latency plus margin
  localparam int DRAIN_LIMIT    = 2000;
  localparam int LIMIT_CYCLES   = 8000000;
  localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code, block leaves its state unchanged

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // angle[7:0], adc_sample[17:8], zero pad
  logic [1:0]  s_axis_tuser = ACT_TICK;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // pwm_level[0], pulse_ticks[13:1], position[21:14]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;       // steer_limit

  int outstanding;
  int mismatches;
  int reports_checked;
  int pulses_started;
  int eager_left = 0;
  int n_requests = 0;

  servo_steering_pwm #(
    .PERIOD_TICKS (PERIOD)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  servo_steering_pwm_check #(
    .PERIOD_TICKS (PERIOD)
  ) u_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .outstanding     (outstanding),
    .mismatches      (mismatches),
    .reports_checked (reports_checked),
    .pulses_started  (pulses_started)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_CYCLES * 4);
    $display("servo_steering_pwm_test: FAIL");
    $finish;
  end

  // idle cycles before a request: mostly none, a few long ones,
  // and now and then a burst with no gaps at all
  function automatic int pick_gap();
    int r;
    if (eager_left > 0) begin
      eager_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      eager_left = $urandom_range(100, 400);
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  // angles weighted toward the clamp edges
  function automatic logic [7:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(178 + $urandom_range(0, 4));
      3: return 8'($urandom_range(0, 20));
      default: return 8'($urandom);
    endcase
  endfunction

  // samples weighted toward the rails and the truncation steps of the offset
  function automatic logic [9:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      2, 3: begin
        v = 511 + 30 * ($urandom_range(0, 33) - 17) + $urandom_range(0, 2) - 1;
        if (v < 0) begin
          v = 0;
        end
        if (v > 1023) begin
          v = 1023;
        end
        return 10'(v);
      end
      default: return 10'($urandom);
    endcase
  endfunction

  // offer one request and hold it until the block takes it
  task automatic offer(input logic [1:0] act, input logic [7:0] ang, input logic [9:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {6'b0, smp, ang};
    do @(posedge clk); while (!s_axis_tready);
    n_requests++;
  endtask

  // stop offering and let every due result come out
  task automatic settle();
    int waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // limit register write, only while the block is idle
  task automatic write_limit(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls and ready runs, one assignment per edge;
  // after a number of results it holds off long enough for the queue to
  // fill and the input side to stall
  initial begin : sink_side
    int   left;
    int   taken;
    int   hold_mark;
    logic level;
    left = 0;
    taken = 0;
    hold_mark = 500;
    level = 1'b1;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        taken++;
      end
      if (left > 0) begin
        left--;
      end else if (taken >= hold_mark) begin
        level = 1'b0;
        left = 300;
        hold_mark = taken + 9000;
      end else if (!level || $urandom_range(0, 2) == 0) begin
        level = 1'b1;
        left = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
      end else begin
        level = 1'b0;
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      m_axis_tready <= level;
    end
  end

  initial begin : source_side
    int         changes;
    int         run;
    int         r;
    int         phase;
    logic [7:0] limit_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset limit of 120
    offer(ACT_TICK, 8'd0, 10'd0);          // tick before any command, pin stays low
    offer(ACT_NONE, 8'd255, 10'd1023);     // unused action, state unchanged
    offer(ACT_CAL, 8'd0, 10'd1023);        // largest positive offset
    offer(ACT_TICK, 8'd255, 10'd1023);
    offer(ACT_CMD, 8'd255, 10'd0);         // first command, clamps high, starts the frame
    offer(ACT_TICK, 8'd0, 10'd0);          // low phase ends at once, high time latched
    offer(ACT_TICK, 8'd0, 10'd0);
    offer(ACT_CAL, 8'd0, 10'd0);           // largest negative offset
    offer(ACT_CMD, 8'd0, 10'd0);           // sum below zero clamps to zero
    offer(ACT_CMD, 8'd16, 10'd0);          // just below zero
    offer(ACT_CMD, 8'd197, 10'd0);         // exactly full scale after offset
    offer(ACT_CAL, 8'd0, 10'd511);         // midpoint, zero offset
    offer(ACT_CMD, 8'd180, 10'd0);
    offer(ACT_CMD, 8'd181, 10'd0);         // one past full scale
    offer(ACT_CAL, 8'd0, 10'd540);         // truncation toward zero, both sides
    offer(ACT_CAL, 8'd0, 10'd541);
    offer(ACT_CAL, 8'd0, 10'd481);
    offer(ACT_CAL, 8'd0, 10'd482);
    offer(ACT_CMD, 8'd1, 10'd0);
    offer(ACT_NONE, 8'd0, 10'd0);
    offer(ACT_TICK, 8'd0, 10'd0);
    settle();

    // random phases, each at its own limit, extremes first
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: limit_val = 8'd0;
        1: limit_val = 8'd180;
        2: limit_val = 8'd255;   // above full scale, position goes past 180
        3: limit_val = 8'd1;
        default: limit_val = 8'($urandom);
      endcase
      write_limit(limit_val);
      changes = 0;
      while (changes < CHANGES_PER_PH) begin
        // runs of ticks, mostly short and now and then longer
        r = $urandom_range(0, 99);
        if (r < 75) begin
          run = $urandom_range(0, 6);
        end else if (r < 97) begin
          run = $urandom_range(10, 30);
        end else begin
          run = $urandom_range(60, 120);
        end
        repeat (run) offer(ACT_TICK, 8'($urandom), 10'($urandom));
        r = $urandom_range(0, 19);
        if (r < 2) begin
          offer(ACT_NONE, 8'($urandom), 10'($urandom));
        end else if (r < 9) begin
          offer(ACT_CAL, 8'($urandom), pick_sample());
          changes++;
        end else begin
          offer(ACT_CMD, pick_angle(), 10'($urandom));
          changes++;
        end
      end
      settle();
    end

    if (outstanding != 0) begin
      $error("%0d results never arrived", outstanding);
    end
    $display("run covered %0d requests over 6 limit settings", n_requests);
    $display("%0d results checked, %0d high pulses started", reports_checked, pulses_started);
    if (mismatches == 0 && outstanding == 0) begin
      $display("servo_steering_pwm_test: PASS");
    end else begin
      $display("servo_steering_pwm_test: FAIL");
    end
    $finish;
  end

endmodule
